// ===== hdl/ef4_pkg.sv =====
// ----------------------------------------------------------------------------
// ef4_pkg
// Shared types, constants and tables of the four-exposure fusion block.
// ----------------------------------------------------------------------------
package ef4_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int COL_W     = 11;
	localparam int ROW_W     = 16;
	localparam int FW_W      = 12;
	localparam int FH_W      = 16;
	localparam int CFG_DW    = 16;
	localparam int ADDR_W    = 12;
	localparam int BUF_DEPTH = 4096;
	localparam int PIX_W     = 24;
	localparam int WORD_W    = 96;
	localparam int LAP_W     = 20;
	localparam int WGT_W     = 28;
	localparam int SUM_W     = 30;
	localparam int NUM_W     = 38;
	localparam int DIVN_W    = 42;

	localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [FW_W-1:0] WIDTH_RST  = 12'd640;
	localparam logic [FH_W-1:0] HEIGHT_RST = 16'd480;

	typedef struct packed {
		logic [7:0] e1_red;
		logic [7:0] e1_green;
		logic [7:0] e1_blue;
		logic [7:0] e2_red;
		logic [7:0] e2_green;
		logic [7:0] e2_blue;
		logic [7:0] e3_red;
		logic [7:0] e3_green;
		logic [7:0] e3_blue;
		logic [7:0] e4_red;
		logic [7:0] e4_green;
		logic [7:0] e4_blue;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] fused_red;
		logic signed [15:0] fused_green;
		logic signed [15:0] fused_blue;
		logic               zero_weight;
		logic               frame_end;
	} out_item_t;

	// pixel words: red 7..0, green 15..8, blue 23..16
	typedef struct packed {
		logic [PIX_W-1:0] up;
		logic [PIX_W-1:0] left;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] right;
		logic [PIX_W-1:0] down;
	} pix5_t;

	// long division, used only while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] rem;
		logic [63:0] q;
		int          i;
		rem = '0;
		q = '0;
		for (i = 63; i >= 0; i--) begin
			rem = {rem[63:0], a[i]};
			if (rem >= {1'b0, b}) begin
				rem = rem - {1'b0, b};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [4095:0] expo_table_f();
		logic [63:0]   d;
		logic [63:0]   t;
		logic [63:0]   term;
		logic [63:0]   e;
		logic [63:0]   v;
		logic [4095:0] tbl;
		int            x;
		int            n;
		tbl = '0;
		for (x = 0; x < 256; x++) begin
			if (2 * x >= 255)
				d = 64'(2 * x - 255);
			else
				d = 64'(255 - 2 * x);
			t = udiv64(d * d * 64'd25 * (64'd1 << 24), 64'd520200);
			term = 64'd1 << 24;
			e = term;
			for (n = 1; n <= 40; n++) begin
				term = udiv64(term * t, 64'(n) << 24);
				e = e + term;
			end
			v = udiv64((64'd1 << 40) + (e >> 1), e);
			tbl[x*16 +: 16] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
		end
		return tbl;
	endfunction

	localparam logic [4095:0] EXPO_TABLE = expo_table_f();

	function automatic logic [15:0] expo_lookup(input logic [7:0] x);
		return EXPO_TABLE[{x, 4'b0000} +: 16];
	endfunction

	function automatic logic [23:0] luma_num(input logic [PIX_W-1:0] px);
		return 24'd13933 * {16'd0, px[7:0]} + 24'd46871 * {16'd0, px[15:8]} +
			24'd4732 * {16'd0, px[23:16]} + 24'd127;
	endfunction

endpackage

// ===== hdl/ef4_line_buf.sv =====
// ----------------------------------------------------------------------------
// ef4_line_buf
// Two-row line buffer of all four exposures, one 96-bit word per column.
// ----------------------------------------------------------------------------
module ef4_line_buf import ef4_pkg::*; (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WORD_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WORD_W-1:0] wr_data
);

	logic [WORD_W-1:0] mem [BUF_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

// ===== hdl/ef4_weight.sv =====
// ----------------------------------------------------------------------------
// ef4_weight
// Weight of one exposure: deviation x Laplacian of luma x exposedness.
// ----------------------------------------------------------------------------
module ef4_weight import ef4_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  pix5_t                   pix,
	output logic                    done,
	output logic signed [WGT_W-1:0] weight
);

	localparam logic [3:0] W_IDLE = 4'd0;
	localparam logic [3:0] W_LUMA = 4'd1;
	localparam logic [3:0] W_SQRT = 4'd2;
	localparam logic [3:0] W_DIV3 = 4'd3;
	localparam logic [3:0] W_P1   = 4'd4;
	localparam logic [3:0] W_P2   = 4'd5;
	localparam logic [3:0] W_M1   = 4'd6;
	localparam logic [3:0] W_M2   = 4'd7;
	localparam logic [3:0] W_DONE = 4'd8;

	logic [3:0]              state_q;
	logic [2:0]              cnt_q;
	pix5_t                   pix_q;
	logic [23:0]             n_s1;
	logic [2:0]              idx_s1;
	logic signed [LAP_W-1:0] lap_q;
	logic [33:0]             v_q;
	logic [33:0]             res_q;
	logic [33:0]             sq_bit_q;
	logic [15:0]             sd_q;
	logic [15:0]             t1_q;
	logic [15:0]             p_q;
	logic signed [36:0]      m1_q;
	logic signed [53:0]      m2_q;

	logic [PIX_W-1:0] sel_px;
	logic [17:0]      sq_sum;
	logic [9:0]       ch_sum;
	logic [19:0]      var_v;
	logic [39:0]      lprod;
	logic [16:0]      lq0;
	logic [23:0]      lrem;
	logic [16:0]      ly;
	logic [15:0]      ysat;
	logic [33:0]      trial;
	logic [31:0]      d3prod;
	logic [15:0]      d3q;
	logic [16:0]      d3rem;
	logic [31:0]      tprod1;
	logic [31:0]      tprod2;

	always_comb begin
		case (cnt_q)
			3'd0:    sel_px = pix_q.up;
			3'd1:    sel_px = pix_q.left;
			3'd2:    sel_px = pix_q.mid;
			3'd3:    sel_px = pix_q.right;
			default: sel_px = pix_q.down;
		endcase
		sq_sum = {10'd0, pix.mid[7:0]} * {10'd0, pix.mid[7:0]} +
			{10'd0, pix.mid[15:8]} * {10'd0, pix.mid[15:8]} +
			{10'd0, pix.mid[23:16]} * {10'd0, pix.mid[23:16]};
		ch_sum = {2'd0, pix.mid[7:0]} + {2'd0, pix.mid[15:8]} + {2'd0, pix.mid[23:16]};
		var_v = 20'd3 * {2'd0, sq_sum} - {10'd0, ch_sum} * {10'd0, ch_sum};
		// floor(n/255): reciprocal estimate low by at most one
		lprod = {16'd0, n_s1} * 40'd32896;
		lq0 = lprod[39:23];
		lrem = n_s1 - 24'({7'd0, lq0} * 24'd255);
		ly = (lrem >= 24'd255) ? lq0 + 17'd1 : lq0;
		ysat = ly[16] ? 16'hFFFF : ly[15:0];
		trial = res_q + sq_bit_q;
		d3prod = {15'd0, res_q[16:0]} * 32'd21845;
		d3q = d3prod[31:16];
		d3rem = res_q[16:0] - 17'({1'b0, d3q} * 17'd3);
		tprod1 = expo_lookup(pix_q.mid[7:0]) * expo_lookup(pix_q.mid[15:8]);
		tprod2 = t1_q * expo_lookup(pix_q.mid[23:16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				W_IDLE: begin
					cnt_q <= '0;
					if (start)
						state_q <= W_LUMA;
				end
				W_LUMA: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd5)
						state_q <= W_SQRT;
				end
				W_SQRT: if (sq_bit_q == 34'd1) state_q <= W_DIV3;
				W_DIV3: state_q <= W_P1;
				W_P1:   state_q <= W_P2;
				W_P2:   state_q <= W_M1;
				W_M1:   state_q <= W_M2;
				W_M2:   state_q <= W_DONE;
				W_DONE: state_q <= W_IDLE;
				default: state_q <= W_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			W_IDLE: begin
				if (start) begin
					pix_q    <= pix;
					lap_q    <= '0;
					v_q      <= {var_v[17:0], 16'd0};
					res_q    <= '0;
					sq_bit_q <= 34'd1 << 32;
				end
			end
			W_LUMA: begin
				if (cnt_q < 3'd5) begin
					n_s1   <= luma_num(sel_px);
					idx_s1 <= cnt_q;
				end
				if (cnt_q != 3'd0) begin
					if (idx_s1 == 3'd2)
						lap_q <= lap_q + $signed({2'b00, ysat, 2'b00});
					else
						lap_q <= lap_q - $signed({4'b0000, ysat});
				end
			end
			W_SQRT: begin
				if (v_q >= trial) begin
					v_q   <= v_q - trial;
					res_q <= (res_q >> 1) + sq_bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			W_DIV3: sd_q <= (d3rem >= 17'd3) ? d3q + 16'd1 : d3q;
			W_P1:   t1_q <= tprod1[31:16];
			W_P2:   p_q  <= tprod2[31:16];
			W_M1:   m1_q <= $signed({1'b0, sd_q}) * lap_q;
			W_M2:   m2_q <= m1_q * $signed({1'b0, p_q});
			default: ;
		endcase
	end

	assign done   = (state_q == W_DONE);
	assign weight = WGT_W'(m2_q >>> 24);

endmodule

// ===== hdl/ef4_div.sv =====
// ----------------------------------------------------------------------------
// ef4_div
// Signed divide, rounded half away from zero, saturated to 16 bits.
// Restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ef4_div import ef4_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DIVN_W-1:0] num,
	input  logic signed [SUM_W-1:0]  den,
	output logic                     done,
	output logic signed [15:0]       quo
);

	localparam int NN_W = DIVN_W + 2;

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_RUN  = 2'd1;
	localparam logic [1:0] D_DONE = 2'd2;

	logic [1:0]        state_q;
	logic [5:0]        cnt_q;
	logic              neg_q;
	logic [NN_W-1:0]   nn_q;
	logic [SUM_W:0]    dd_q;
	logic [SUM_W+1:0]  rem_q;
	logic [NN_W-1:0]   q_q;

	logic [DIVN_W-1:0] an;
	logic [SUM_W-1:0]  ad;
	logic [SUM_W+1:0]  trial;

	always_comb begin
		an = num[DIVN_W-1] ? DIVN_W'(-num) : num;
		ad = den[SUM_W-1] ? SUM_W'(-den) : den;
		trial = {rem_q[SUM_W:0], nn_q[NN_W-1]};
		if (neg_q)
			quo = (q_q > NN_W'(32768)) ? 16'sh8000 : $signed(~q_q[15:0] + 16'd1);
		else
			quo = (q_q > NN_W'(32767)) ? 16'sh7FFF : $signed(q_q[15:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_RUN;
						cnt_q   <= 6'(NN_W - 1);
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0)
						state_q <= D_DONE;
				end
				D_DONE:  state_q <= D_IDLE;
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			neg_q <= num[DIVN_W-1] ^ den[SUM_W-1];
			nn_q  <= {an, 1'b0} + {{(NN_W-SUM_W){1'b0}}, ad};
			dd_q  <= {ad, 1'b0};
			rem_q <= '0;
			q_q   <= '0;
		end else if (state_q == D_RUN) begin
			if (trial >= {1'b0, dd_q}) begin
				rem_q <= trial - {1'b0, dd_q};
				q_q   <= {q_q[NN_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[NN_W-2:0], 1'b0};
			end
			nn_q <= nn_q << 1;
		end
	end

	assign done = (state_q == D_DONE);

endmodule

// ===== hdl/exposure_fusion_four_frames.sv =====
// ----------------------------------------------------------------------------
// exposure_fusion_four_frames
// Single-scale fusion of four co-located RGB exposures, raster streaming.
// ----------------------------------------------------------------------------
//  port group   dir   transfer when            payload
//  in_*         in    in_valid && !in_stall    in_item_t (four RGB pixels)
//  out_*        out   out_valid && !out_stall  out_item_t (fused pixel, flags)
//  cfg_*        in    cfg_we                   cfg_index, cfg_data
//
//  Border pixel: accept, then line buffer write.
//  Interior pixel: accept, 4 buffer reads, write, four weight passes (17-step
//  square root each) and three divides (44 steps each), then the result load.
//  Reset clears counters and control; line buffer contents are not cleared.
//  A waiting result stalls the block only when the next result is ready.
// ----------------------------------------------------------------------------
module exposure_fusion_four_frames import ef4_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_data,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_READ   = 4'd1;
	localparam logic [3:0] ST_WRITE  = 4'd2;
	localparam logic [3:0] ST_WSTART = 4'd3;
	localparam logic [3:0] ST_WWAIT  = 4'd4;
	localparam logic [3:0] ST_ACC    = 4'd5;
	localparam logic [3:0] ST_DSTART = 4'd6;
	localparam logic [3:0] ST_DWAIT  = 4'd7;
	localparam logic [3:0] ST_OUT    = 4'd8;

	logic [3:0]              state_q;
	logic [FW_W-1:0]         width_q;
	logic [FH_W-1:0]         height_q;
	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic [COL_W-1:0]        c_q;
	logic                    top_q;
	logic                    emit_q;
	logic                    fend_q;
	logic [WORD_W-1:0]       cur_q;
	logic [2:0]              rd_cnt_q;
	logic [WORD_W-1:0]       nbr_q [4];
	logic [1:0]              k_q;
	logic [1:0]              ch_q;
	logic signed [WGT_W-1:0] wt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [NUM_W-1:0] num_q [3];
	logic signed [15:0]      res_q [3];
	logic                    out_valid_q;
	out_item_t               out_q;

	logic [FW_W-1:0]   weff;
	logic [FH_W-1:0]   heff;
	logic              accept;
	logic              emit;
	logic [WORD_W-1:0] cur_word;
	logic              mem_rd;
	logic              mem_wr;
	logic [ADDR_W-1:0] rd_addr;
	logic [WORD_W-1:0] rd_data;
	pix5_t             wpix;
	logic              wgt_start;
	logic              wgt_done;
	logic signed [WGT_W-1:0] wgt_weight;
	logic              div_start;
	logic              div_done;
	logic signed [15:0] div_quo;
	logic [PIX_W-1:0]  mid_px;
	logic signed [NUM_W-1:0] prod [3];
	logic              zero_sum;
	logic              out_load;

	always_comb begin
		if (width_q < 12'd3)
			weff = 12'd3;
		else if (width_q > FW_W'(MAX_WIDTH))
			weff = FW_W'(MAX_WIDTH);
		else
			weff = width_q;
		heff = (height_q < 16'd3) ? 16'd3 : height_q;
		accept = in_valid && !in_stall;
		emit = (row_q >= 16'd2) && (row_q <= heff - 16'd1) && (col_q >= 11'd1) &&
			({1'b0, col_q} <= weff - 12'd2);
		cur_word = {in_data.e4_blue, in_data.e4_green, in_data.e4_red,
			in_data.e3_blue, in_data.e3_green, in_data.e3_red,
			in_data.e2_blue, in_data.e2_green, in_data.e2_red,
			in_data.e1_blue, in_data.e1_green, in_data.e1_red};
		mem_rd = (state_q == ST_READ) && (rd_cnt_q < 3'd4);
		mem_wr = (state_q == ST_WRITE);
		case (rd_cnt_q)
			3'd0:    rd_addr = {top_q, c_q};
			3'd1:    rd_addr = {~top_q, c_q - 11'd1};
			3'd2:    rd_addr = {~top_q, c_q};
			default: rd_addr = {~top_q, c_q + 11'd1};
		endcase
		wpix.up    = nbr_q[0][k_q*24 +: 24];
		wpix.left  = nbr_q[1][k_q*24 +: 24];
		wpix.mid   = nbr_q[2][k_q*24 +: 24];
		wpix.right = nbr_q[3][k_q*24 +: 24];
		wpix.down  = cur_q[k_q*24 +: 24];
		mid_px = wpix.mid;
		prod[0] = $signed({1'b0, mid_px[7:0]}) * NUM_W'(wt_q);
		prod[1] = $signed({1'b0, mid_px[15:8]}) * NUM_W'(wt_q);
		prod[2] = $signed({1'b0, mid_px[23:16]}) * NUM_W'(wt_q);
		wgt_start = (state_q == ST_WSTART);
		div_start = (state_q == ST_DSTART);
		zero_sum = (sum_q == '0);
		out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	ef4_line_buf u_buf (
		.clk     (clk),
		.rd_en   (mem_rd),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (mem_wr),
		.wr_addr ({top_q, c_q}),
		.wr_data (cur_q)
	);

	ef4_weight u_wgt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (wgt_start),
		.pix    (wpix),
		.done   (wgt_done),
		.weight (wgt_weight)
	);

	ef4_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({num_q[ch_q], 4'b0000}),
		.den    (sum_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			width_q     <= WIDTH_RST;
			height_q    <= HEIGHT_RST;
			col_q       <= '0;
			row_q       <= '0;
			rd_cnt_q    <= '0;
			k_q         <= '0;
			ch_q        <= '0;
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  width_q  <= cfg_data[FW_W-1:0];
					REG_FRAME_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					rd_cnt_q <= '0;
					if (accept) begin
						emit_q <= emit;
						if ({1'b0, col_q} >= weff - 12'd1) begin
							col_q <= '0;
							row_q <= (row_q >= heff - 16'd1) ? '0 : row_q + 16'd1;
						end else begin
							col_q <= col_q + 11'd1;
						end
						state_q <= emit ? ST_READ : ST_WRITE;
					end
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 3'd1;
					if (rd_cnt_q == 3'd4)
						state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					k_q     <= '0;
					ch_q    <= '0;
					state_q <= emit_q ? ST_WSTART : ST_IDLE;
				end
				ST_WSTART: state_q <= ST_WWAIT;
				ST_WWAIT:  if (wgt_done) state_q <= ST_ACC;
				ST_ACC: begin
					k_q     <= k_q + 2'd1;
					state_q <= (k_q == 2'd3) ? ST_DSTART : ST_WSTART;
				end
				ST_DSTART: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_done) begin
						ch_q    <= ch_q + 2'd1;
						state_q <= (ch_q == 2'd2) ? ST_OUT : ST_DSTART;
					end
				end
				ST_OUT: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q  <= cur_word;
			c_q    <= col_q;
			top_q  <= row_q[0];
			fend_q <= (row_q == heff - 16'd1) && ({1'b0, col_q} == weff - 12'd2);
		end
		if (state_q == ST_READ && rd_cnt_q != 3'd0)
			nbr_q[2'(rd_cnt_q - 3'd1)] <= rd_data;
		if (state_q == ST_WRITE) begin
			sum_q    <= '0;
			num_q[0] <= '0;
			num_q[1] <= '0;
			num_q[2] <= '0;
		end
		if (state_q == ST_WWAIT && wgt_done)
			wt_q <= wgt_weight;
		if (state_q == ST_ACC) begin
			sum_q    <= sum_q + SUM_W'(wt_q);
			num_q[0] <= num_q[0] + prod[0];
			num_q[1] <= num_q[1] + prod[1];
			num_q[2] <= num_q[2] + prod[2];
		end
		if (state_q == ST_DWAIT && div_done)
			res_q[ch_q] <= div_quo;
		if (out_load) begin
			out_q.fused_red   <= zero_sum ? 16'sd0 : res_q[0];
			out_q.fused_green <= zero_sum ? 16'sd0 : res_q[1];
			out_q.fused_blue  <= zero_sum ? 16'sd0 : res_q[2];
			out_q.zero_weight <= zero_sum;
			out_q.frame_end   <= fend_q;
		end
	end

	a_rd_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_rd && mem_wr)) else $error("line buffer read and write in one cycle");

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_READ || state_q == ST_WRITE))
		else $error("transfer not followed by buffer access");

	a_wgt_done: assert property (@(posedge clk) disable iff (!arst_n)
		wgt_done |-> (state_q == ST_WWAIT)) else $error("weight done while not waiting");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DWAIT)) else $error("divide done while not waiting");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q) else $error("result load lost");

endmodule
